[sv/hfw_pkg.sv]
// Shared types and constants for the homography forward pixel warp unit.
// Used by hfw_front, hfw_cell and the top level; depends on nothing.
`default_nettype none
package hfw_pkg;

    localparam int TARGET_WIDTH  = 1024;
    localparam int TARGET_HEIGHT = 1024;
    localparam int SOURCE_SIZE   = 2048;

    // Quotient bits resolved by the cell row; covers targets up to 4096.
    localparam int QB      = 12;
    localparam int COORD_W = 11;
    localparam int DST_W   = 10;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int FRAC_SH = 14;
    localparam int REM_W   = MAG_W + FRAC_SH;
    localparam int ADDR_W  = 3;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        REG_XC = 3'd0,
        REG_XR = 3'd1,
        REG_XO = 3'd2,
        REG_YC = 3'd3,
        REG_YR = 3'd4,
        REG_YO = 3'd5,
        REG_ZC = 3'd6,
        REG_ZR = 3'd7
    } t_reg_idx;

    localparam logic [COEF_W-1:0] UNITY_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] xc, xr, xo, yc, yr, yo, zc, zr;
    } t_coefs;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // Word handed from one division cell to the next.
    typedef struct packed {
        logic             ok;      // Z nonzero and source inside the frame
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;   // quotient magnitude beyond QB bits
        logic             ovf_y;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [REM_W-1:0] div;     // divisor, shifted left by the bits still to come
        logic [QB-1:0]    q_x;
        logic [QB-1:0]    q_y;
        t_pix             pix;
    } t_cell;

endpackage
`default_nettype wire

[sv/hfw_front.sv]
// Front pipeline: products, sums, magnitudes and the overflow check that seed the cell row.
// Depends on hfw_pkg.
`default_nettype none
module hfw_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [hfw_pkg::COORD_W-1:0]   i_col,
    input  wire logic [hfw_pkg::COORD_W-1:0]   i_row,
    input  wire hfw_pkg::t_pix                 i_pix,
    input  wire hfw_pkg::t_coefs               i_coefs,
    output hfw_pkg::t_cell                     o_cell,
    output logic                               o_valid
);
    localparam int PW = hfw_pkg::PROD_W;
    localparam int SW = hfw_pkg::SUM_W;
    localparam int MW = hfw_pkg::MAG_W;
    localparam int RW = hfw_pkg::REM_W;

    logic [3:0] r_vld;

    // Stage 1: six products, offsets and range flag.
    logic signed [PW-1:0] r_pxc, r_pxr, r_pyc, r_pyr, r_pzc, r_pzr;
    logic signed [hfw_pkg::COEF_W-1:0] r_xo, r_yo;
    logic r_ok1;
    hfw_pkg::t_pix r_pix1;
    logic signed [hfw_pkg::COORD_W:0] w_c, w_r;
    assign w_c = $signed({1'b0, i_col});
    assign w_r = $signed({1'b0, i_row});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxc  <= $signed(i_coefs.xc) * w_c;
            r_pxr  <= $signed(i_coefs.xr) * w_r;
            r_pyc  <= $signed(i_coefs.yc) * w_c;
            r_pyr  <= $signed(i_coefs.yr) * w_r;
            r_pzc  <= $signed(i_coefs.zc) * w_c;
            r_pzr  <= $signed(i_coefs.zr) * w_r;
            r_xo   <= i_coefs.xo;
            r_yo   <= i_coefs.yo;
            r_ok1  <= (32'(i_col) < 32'(hfw_pkg::SOURCE_SIZE)) &&
                      (32'(i_row) < 32'(hfw_pkg::SOURCE_SIZE));
            r_pix1 <= i_pix;
        end
    end

    // Stage 2: numerators and denominator.
    logic signed [SW-1:0] r_x, r_y, r_z;
    logic r_ok2;
    hfw_pkg::t_pix r_pix2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= SW'(r_pxc) + SW'(r_pxr) + SW'(r_xo);
            r_y    <= SW'(r_pyc) + SW'(r_pyr) + SW'(r_yo);
            r_z    <= SW'(r_pzc) + SW'(r_pzr) + hfw_pkg::ONE_Q30;
            r_ok2  <= r_ok1;
            r_pix2 <= r_pix1;
        end
    end

    // Stage 3: magnitudes and quotient signs.
    logic [SW-1:0] n_ax, n_ay, n_az;
    logic [RW-1:0] r_nx, r_ny, r_d;
    logic r_sx, r_sy, r_ok3;
    hfw_pkg::t_pix r_pix3;
    always_comb begin
        n_ax = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
        n_ay = r_y[SW-1] ? SW'(-r_y) : SW'(r_y);
        n_az = r_z[SW-1] ? SW'(-r_z) : SW'(r_z);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx   <= {n_ax[MW-1:0], hfw_pkg::FRAC_SH'(0)};
            r_ny   <= {n_ay[MW-1:0], hfw_pkg::FRAC_SH'(0)};
            r_d    <= {hfw_pkg::FRAC_SH'(0), n_az[MW-1:0]};
            r_sx   <= r_x[SW-1] ^ r_z[SW-1];
            r_sy   <= r_y[SW-1] ^ r_z[SW-1];
            r_ok3  <= r_ok2 && (r_z != '0);
            r_pix3 <= r_pix2;
        end
    end

    // Stage 4: quotient overflow check against the divisor shifted by all QB bits.
    logic [RW-1:0] w_dsh;
    assign w_dsh = r_d << hfw_pkg::QB;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cell.ok    <= r_ok3;
            o_cell.neg_x <= r_sx;
            o_cell.neg_y <= r_sy;
            o_cell.ovf_x <= r_nx >= w_dsh;
            o_cell.ovf_y <= r_ny >= w_dsh;
            o_cell.rem_x <= r_nx;
            o_cell.rem_y <= r_ny;
            o_cell.div   <= w_dsh;
            o_cell.q_x   <= '0;
            o_cell.q_y   <= '0;
            o_cell.pix   <= r_pix3;
        end
    end

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end
    assign o_valid = r_vld[3];

endmodule
`default_nettype wire

[sv/hfw_cell.sv]
// One restoring-division cell: resolves one quotient bit for X and for Y per word.
// Depends on hfw_pkg.
`default_nettype none
module hfw_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire hfw_pkg::t_cell i_cell,
    output hfw_pkg::t_cell      o_cell,
    output logic                o_valid
);
    logic [hfw_pkg::REM_W-1:0] w_d;
    logic w_bx, w_by;
    hfw_pkg::t_cell n_cell;

    // Compare and subtract against the divisor at this bit's weight.
    always_comb begin
        w_d    = i_cell.div >> 1;
        w_bx   = i_cell.rem_x >= w_d;
        w_by   = i_cell.rem_y >= w_d;
        n_cell = i_cell;
        n_cell.div   = w_d;
        n_cell.rem_x = w_bx ? i_cell.rem_x - w_d : i_cell.rem_x;
        n_cell.rem_y = w_by ? i_cell.rem_y - w_d : i_cell.rem_y;
        n_cell.q_x   = {i_cell.q_x[hfw_pkg::QB-2:0], w_bx};
        n_cell.q_y   = {i_cell.q_y[hfw_pkg::QB-2:0], w_by};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule
`default_nettype wire

[sv/homography_forward_pixel_warp_unit.sv]
// Maps each source pixel through a 3x3 homography and emits the destination
// position with its colors; the pipeline takes one word per clock and a word
// passes through four front stages of products, sums, magnitudes and overflow
// check, twelve division cells of one quotient bit each, and the output
// register. Only back pressure on the output slows it.
// Depends on hfw_pkg, hfw_front and hfw_cell.
`default_nettype none
module homography_forward_pixel_warp_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    // Pixel input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: src_col[10:0], src_row[21:11], in_blue[29:22], in_green[37:30],
    // in_red[45:38], zero pad [47:46]
    input  wire logic [47:0] s_axis_tdata,
    // Destination stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: dst_col[9:0], dst_row[19:10], out_blue[27:20], out_green[35:28],
    // out_red[43:36], zero pad [47:44]
    output logic [47:0]      m_axis_tdata,
    // tuser: write_enable
    output logic             m_axis_tuser
);
    localparam int QB = hfw_pkg::QB;

    hfw_pkg::t_coefs r_coefs;
    logic w_en;

    // Coefficient registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.xc <= hfw_pkg::UNITY_Q16;
            r_coefs.xr <= '0;
            r_coefs.xo <= '0;
            r_coefs.yc <= '0;
            r_coefs.yr <= hfw_pkg::UNITY_Q16;
            r_coefs.yo <= '0;
            r_coefs.zc <= '0;
            r_coefs.zr <= '0;
        end else if (i_cfg_we) begin
            case (hfw_pkg::t_reg_idx'(i_cfg_addr))
                hfw_pkg::REG_XC: r_coefs.xc <= i_cfg_data;
                hfw_pkg::REG_XR: r_coefs.xr <= i_cfg_data;
                hfw_pkg::REG_XO: r_coefs.xo <= i_cfg_data;
                hfw_pkg::REG_YC: r_coefs.yc <= i_cfg_data;
                hfw_pkg::REG_YR: r_coefs.yr <= i_cfg_data;
                hfw_pkg::REG_YO: r_coefs.yo <= i_cfg_data;
                hfw_pkg::REG_ZC: r_coefs.zc <= i_cfg_data;
                hfw_pkg::REG_ZR: r_coefs.zr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished word is held at the output.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    hfw_pkg::t_pix w_pix;
    assign w_pix.blue  = s_axis_tdata[29:22];
    assign w_pix.green = s_axis_tdata[37:30];
    assign w_pix.red   = s_axis_tdata[45:38];

    hfw_pkg::t_cell w_cell [QB+1];
    logic           w_vld  [QB+1];

    hfw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_col   (s_axis_tdata[10:0]),
        .i_row   (s_axis_tdata[21:11]),
        .i_pix   (w_pix),
        .i_coefs (r_coefs),
        .o_cell  (w_cell[0]),
        .o_valid (w_vld[0])
    );

    // Row of division cells, most significant quotient bit first.
    for (genvar k = 0; k < QB; k++) begin : g_cell
        hfw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[k]),
            .i_cell  (w_cell[k]),
            .o_cell  (w_cell[k+1]),
            .o_valid (w_vld[k+1])
        );
    end

    // Range decision and output register.
    hfw_pkg::t_cell w_fin;
    logic w_we;
    assign w_fin = w_cell[QB];
    always_comb begin
        w_we = w_fin.ok && !w_fin.ovf_x && !w_fin.ovf_y
            && !(w_fin.neg_x && (w_fin.q_x != '0))
            && !(w_fin.neg_y && (w_fin.q_y != '0))
            && (32'(w_fin.q_x) < 32'(hfw_pkg::TARGET_WIDTH))
            && (32'(w_fin.q_y) < 32'(hfw_pkg::TARGET_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata[9:0]   <= w_we ? w_fin.q_x[hfw_pkg::DST_W-1:0] : '0;
            m_axis_tdata[19:10] <= w_we ? w_fin.q_y[hfw_pkg::DST_W-1:0] : '0;
            m_axis_tdata[27:20] <= w_fin.pix.blue;
            m_axis_tdata[35:28] <= w_fin.pix.green;
            m_axis_tdata[43:36] <= w_fin.pix.red;
            m_axis_tdata[47:44] <= '0;
            m_axis_tuser        <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= w_vld[QB];
        end
    end

    // A refused pixel always carries a zero position.
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[19:0] == '0))
        else $error("refused pixel with nonzero destination");

    // A written pixel lies inside the target.
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        ((32'(m_axis_tdata[9:0]) < 32'(hfw_pkg::TARGET_WIDTH)) &&
         (32'(m_axis_tdata[19:10]) < 32'(hfw_pkg::TARGET_HEIGHT))))
        else $error("written pixel outside target");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // A stalled output word is not replaced.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled output word changed");

endmodule
`default_nettype wire
